### hw/rtl/fsr_pkg.sv
// Shared types and constants for the flag set reducer.
// Has no dependencies; imported by fsr_most_table and flag_set_reducer_core.
package fsr_pkg;

    // Combine modes held in the combine_mode register.
    typedef enum logic [2:0] {
        MODE_OR   = 3'd0,
        MODE_AND  = 3'd1,
        MODE_MIN  = 3'd2,
        MODE_MAX  = 3'd3,
        MODE_MOST = 3'd4
    } fsr_mode_t;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int MODE_BITS     = 3;

    // Register index, taken from paddr bit 2 (registers sit on 4-byte steps).
    localparam logic [0:0] REG_COMBINE_MODE = 1'b0;

    localparam int IN_FLAG_BITS  = 32;
    localparam int OUT_FLAG_BITS = 32;
    localparam int OUT_COUNT_BITS = 16;
    localparam int OUT_DATA_BITS = 48;

    // Control from the core to the most-frequent-value table.
    typedef struct packed {
        logic take;     // one pixel enters the table this cycle
        logic restart;  // forget all entries after this cycle
    } fsr_tbl_ctl_t;

endpackage

### hw/rtl/fsr_most_table.sv
// Distinct-value table for the most-frequent-value mode, with a running best.
// Depends on fsr_pkg.
module fsr_most_table
    import fsr_pkg::*;
#(
    parameter int FLAG_BITS  = 32,
    parameter int COUNT_BITS = 16,
    parameter int ENTRIES    = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fsr_tbl_ctl_t          ctl,
    input  logic [FLAG_BITS-1:0]  value,
    output logic [FLAG_BITS-1:0]  best_flag,
    output logic [COUNT_BITS-1:0] best_count,
    output logic                  overflow
);

    localparam int USED_BITS = $clog2(ENTRIES + 1);

    logic [FLAG_BITS-1:0]  table_reg [ENTRIES];
    logic [COUNT_BITS-1:0] counts_reg [ENTRIES];
    logic [USED_BITS-1:0]  used_reg;
    logic [FLAG_BITS-1:0]  best_flag_reg;
    logic [COUNT_BITS-1:0] best_count_reg;
    logic                  overflow_reg;

    logic [ENTRIES-1:0]    match;
    logic                  hit;
    logic [COUNT_BITS-1:0] hit_count;
    logic [COUNT_BITS-1:0] new_count;
    logic                  full;
    logic                  insert;
    logic                  update;
    logic                  better;

    // Entries are distinct, so at most one matches and an OR selects its count.
    always_comb
    begin
        hit_count = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = (USED_BITS'(i) < used_reg) && (table_reg[i] == value);
            if (match[i])
            begin
                hit_count = hit_count | counts_reg[i];
            end
        end
    end

    assign hit       = |match;
    assign full      = (used_reg == USED_BITS'(ENTRIES));
    assign new_count = !hit ? COUNT_BITS'(1)
                     : (hit_count == '1) ? hit_count : hit_count + COUNT_BITS'(1);
    assign insert    = ctl.take && !hit && !full;
    assign update    = ctl.take && (hit || !full);

    // Only one entry changes per pixel, so the best over the table is the
    // better of the old best and the entry just updated.
    assign better = update && ((new_count > best_count_reg) ||
                    ((new_count == best_count_reg) && (value < best_flag_reg)));

    assign best_flag  = better ? value : best_flag_reg;
    assign best_count = better ? new_count : best_count_reg;
    assign overflow   = overflow_reg || (ctl.take && !hit && full);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (ctl.take && match[i])
            begin
                counts_reg[i] <= new_count;
            end
            else if (insert && (USED_BITS'(i) == used_reg))
            begin
                table_reg[i]  <= value;
                counts_reg[i] <= COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            best_flag_reg  <= '0;
            best_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else if (ctl.restart)
        begin
            used_reg       <= '0;
            best_flag_reg  <= '0;
            best_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            if (insert)
            begin
                used_reg <= used_reg + USED_BITS'(1);
            end
            best_flag_reg  <= best_flag;
            best_count_reg <= best_count;
            overflow_reg   <= overflow;
        end
    end

endmodule

### hw/rtl/flag_set_reducer_core.sv
// Top level of the flag set reducer: stream ports, APB register, running
// reduction and result register. Depends on fsr_pkg and fsr_most_table.
//
// The block reduces the flags of one source's pixels, one pixel per input
// transfer, and emits one result transfer after the transfer marked tlast.
// It takes one input transfer per clock unless a tlast transfer is stalled
// in the input register. Each transfer is held in an input register while
// the running accumulators and the parallel compare against all table
// entries update; the result lands in an output register. While a
// result waits on m_axis_tready, later pixels keep flowing; only the next
// tlast transfer waits for the output register to drain. combine_mode may be
// written only while no transfer is in flight; a write restarts the source.
module flag_set_reducer_core
    import fsr_pkg::*;
#(
    parameter int FLAG_BITS    = 32,
    parameter int COUNT_BITS   = 16,
    parameter int MOST_ENTRIES = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_FLAG_BITS-1:0]  s_axis_tdata,   // flag_value[31:0]
    input  logic                     s_axis_tuser,   // no_pixel
    input  logic                     s_axis_tlast,   // last_pixel

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // combined_flag[31:0], pixel_count[47:32]
    output logic                     m_axis_tuser,   // table_overflow
    output logic                     m_axis_tlast,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [MODE_BITS-1:0]  mode_reg;

    logic                  stage_valid_reg;
    logic [FLAG_BITS-1:0]  stage_flag_reg;
    logic                  stage_nopix_reg;
    logic                  stage_last_reg;

    logic [FLAG_BITS-1:0]  run_flag_reg;
    logic [FLAG_BITS-1:0]  run_flag_next;
    logic [COUNT_BITS-1:0] run_count_reg;
    logic [COUNT_BITS-1:0] run_count_next;

    logic                  out_valid_reg;
    logic [FLAG_BITS-1:0]  out_flag_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic                  out_ovf_reg;

    logic                  cfg_wr;
    logic                  in_accept;
    logic                  stage_go;
    logic                  pix;
    logic [COUNT_BITS-1:0] count_inc;
    logic [FLAG_BITS-1:0]  flag_after;
    logic [COUNT_BITS-1:0] count_after;
    logic [FLAG_BITS-1:0]  res_flag;
    logic [COUNT_BITS-1:0] res_count;
    logic                  res_ovf;
    logic [FLAG_BITS-1:0]  start_flag;
    logic [FLAG_BITS-1:0]  new_start_flag;

    fsr_tbl_ctl_t          tbl_ctl;
    logic [FLAG_BITS-1:0]  tbl_flag;
    logic [COUNT_BITS-1:0] tbl_count;
    logic                  tbl_ovf;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_COMBINE_MODE);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_COMBINE_MODE)
        begin
            prdata = CFG_DATA_BITS'(mode_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OR;
        end
        else if (cfg_wr)
        begin
            mode_reg <= pwdata[MODE_BITS-1:0];
        end
    end

    // Input register. A tlast transfer moves on only when the result
    // register is free or draining in the same cycle.
    assign stage_go      = stage_valid_reg &&
                           (!stage_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !stage_valid_reg || stage_go;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (stage_go)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_flag_reg  <= FLAG_BITS'(s_axis_tdata);
            stage_nopix_reg <= s_axis_tuser;
            stage_last_reg  <= s_axis_tlast;
        end
    end

    // Running reduction for the OR, AND, MIN and MAX modes.
    assign pix       = stage_go && !stage_nopix_reg;
    assign count_inc = (run_count_reg == '1) ? run_count_reg
                                             : run_count_reg + COUNT_BITS'(1);

    always_comb
    begin
        flag_after  = run_flag_reg;
        count_after = run_count_reg;
        if (pix)
        begin
            case (mode_reg)
                MODE_OR:
                begin
                    if (stage_flag_reg != '0)
                    begin
                        flag_after  = run_flag_reg | stage_flag_reg;
                        count_after = count_inc;
                    end
                end
                MODE_AND:
                begin
                    flag_after  = run_flag_reg & stage_flag_reg;
                    count_after = count_inc;
                end
                MODE_MIN:
                begin
                    if (stage_flag_reg < run_flag_reg)
                    begin
                        flag_after  = stage_flag_reg;
                        count_after = COUNT_BITS'(1);
                    end
                    else if (stage_flag_reg == run_flag_reg)
                    begin
                        count_after = count_inc;
                    end
                end
                MODE_MAX:
                begin
                    if (stage_flag_reg > run_flag_reg)
                    begin
                        flag_after  = stage_flag_reg;
                        count_after = COUNT_BITS'(1);
                    end
                    else if (stage_flag_reg == run_flag_reg)
                    begin
                        count_after = count_inc;
                    end
                end
                default:
                begin
                    flag_after  = run_flag_reg;
                    count_after = run_count_reg;
                end
            endcase
        end
    end

    assign tbl_ctl.take    = pix && (mode_reg == MODE_MOST);
    assign tbl_ctl.restart = cfg_wr || (stage_go && stage_last_reg);

    fsr_most_table #(
        .FLAG_BITS  (FLAG_BITS),
        .COUNT_BITS (COUNT_BITS),
        .ENTRIES    (MOST_ENTRIES)
    ) u_most_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tbl_ctl),
        .value      (stage_flag_reg),
        .best_flag  (tbl_flag),
        .best_count (tbl_count),
        .overflow   (tbl_ovf)
    );

    // Result of the source, including the pixel in the input register.
    always_comb
    begin
        res_flag  = '0;
        res_count = '0;
        res_ovf   = 1'b0;
        case (mode_reg)
            MODE_OR, MODE_AND:
            begin
                res_flag  = flag_after;
                res_count = count_after;
            end
            MODE_MIN, MODE_MAX:
            begin
                res_count = count_after;
                res_flag  = (count_after == '0) ? '0 : flag_after;
            end
            MODE_MOST:
            begin
                res_flag  = tbl_flag;
                res_count = tbl_count;
                res_ovf   = tbl_ovf;
            end
            default:
            begin
                res_flag  = '0;
                res_count = '0;
                res_ovf   = 1'b0;
            end
        endcase
    end

    // AND and MIN start from all ones, the others from zero.
    assign start_flag     = ((mode_reg == MODE_AND) || (mode_reg == MODE_MIN)) ? '1 : '0;
    assign new_start_flag = ((pwdata[MODE_BITS-1:0] == MODE_AND) ||
                             (pwdata[MODE_BITS-1:0] == MODE_MIN)) ? '1 : '0;

    always_comb
    begin
        run_flag_next  = flag_after;
        run_count_next = count_after;
        if (cfg_wr)
        begin
            run_flag_next  = new_start_flag;
            run_count_next = '0;
        end
        else if (stage_go && stage_last_reg)
        begin
            run_flag_next  = start_flag;
            run_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_flag_reg  <= '0;
            run_count_reg <= '0;
        end
        else
        begin
            run_flag_reg  <= run_flag_next;
            run_count_reg <= run_count_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go && stage_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && stage_last_reg)
        begin
            out_flag_reg  <= res_flag;
            out_count_reg <= res_count;
            out_ovf_reg   <= res_ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {OUT_COUNT_BITS'(out_count_reg), OUT_FLAG_BITS'(out_flag_reg)};
    assign m_axis_tuser  = out_ovf_reg;
    assign m_axis_tlast  = 1'b1;

endmodule
